// ===== rtl/direct_mapped_cache_miss_classifier_assert.svh =====
// Assertion macros for the cache miss classifier; clk and rst_n must be in scope.
`ifndef DIRECT_MAPPED_CACHE_MISS_CLASSIFIER_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_MISS_CLASSIFIER_ASSERT_SVH

// Property that holds at every edge out of reset.
`define DMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dmc_pkg.sv =====
`default_nettype none

package dmc_pkg;

    localparam int DMC_MAX_SETS = 1024;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int SET_OUT_W  = 10;
    localparam int OFFSET_W   = 5;
    localparam int INDEX_W    = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd2;
    localparam logic [INDEX_W-1:0]  INDEX_RESET  = 4'd8;

    typedef enum logic [1:0] {
        OUT_HIT,
        OUT_COMPULSORY,
        OUT_CONFLICT,
        OUT_CAPACITY
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic lookup;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_stall;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/dmc_ctrl.sv =====
`default_nettype none

`include "direct_mapped_cache_miss_classifier_assert.svh"

module dmc_ctrl
    import dmc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!status.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.lookup = in_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = !status.out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `DMC_ASSERT_NEXT(a_accept_to_update, in_valid && in_ready, state_reg == ST_UPDATE, "item accepted but no update follows")
    `DMC_ASSERT(a_no_accept_in_clear, !(state_reg == ST_CLEAR && cmd.lookup), "lookup during clearing pass")
    `DMC_ASSERT_NEXT(a_stall_holds, state_reg == ST_UPDATE && status.out_stall, state_reg == ST_UPDATE, "update left while output stalled")

endmodule

`default_nettype wire

// ===== rtl/dmc_datapath.sv =====
`default_nettype none

`include "direct_mapped_cache_miss_classifier_assert.svh"

module dmc_datapath
    import dmc_pkg::*;
#(
    parameter int MAX_SETS = DMC_MAX_SETS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  write_en,
    input  wire logic [CFG_IDX_W-1:0]  reg_index,
    input  wire logic [CFG_DATA_W-1:0] write_data,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 outcome,
    output logic [SET_OUT_W-1:0]       set_index,
    output logic [TAG_W-1:0]           tag_value
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int FILL_W  = $clog2(MAX_SETS + 1);
    localparam int IB_MAX  = $clog2(MAX_SETS + 1) - 1;
    localparam int SHIFT_W = 6;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } line_t;

    line_t mem [MAX_SETS];

    logic [OFFSET_W-1:0] offset_bits_reg;
    logic [INDEX_W-1:0]  index_bits_reg;
    logic [SET_W-1:0]    clr_cnt_reg;
    logic [SET_W-1:0]    clr_cnt_next;
    logic [FILL_W-1:0]   filled_lines_reg;
    logic [FILL_W-1:0]   filled_lines_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    line_t               rd_reg;
    outcome_t            outcome_reg;
    logic [SET_OUT_W-1:0] set_index_reg;
    logic [TAG_W-1:0]    tag_value_reg;

    logic [4:0]          ib_eff;
    logic [SHIFT_W-1:0]  shift_amt;
    logic [32:0]         set_mask;
    logic [ADDR_W-1:0]   set_full;
    logic [SET_W-1:0]    lk_set;
    logic [TAG_W-1:0]    lk_tag;
    logic [FILL_W-1:0]   sets_in_use;
    logic [31:0]         set_ext;

    outcome_t            outcome_next;
    logic                miss;
    logic                mem_we;
    logic [SET_W-1:0]    mem_waddr;
    line_t               mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_RESET;
            index_bits_reg  <= INDEX_RESET;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_OFFSET_BITS:
                begin
                    offset_bits_reg <= write_data[OFFSET_W-1:0];
                end
                REG_INDEX_BITS:
                begin
                    index_bits_reg <= write_data[INDEX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        ib_eff      = ({1'b0, index_bits_reg} > 5'(IB_MAX)) ? 5'(IB_MAX) : {1'b0, index_bits_reg};
        shift_amt   = SHIFT_W'(offset_bits_reg) + SHIFT_W'(ib_eff);
        set_mask    = (33'd1 << ib_eff) - 33'd1;
        set_full    = (address >> offset_bits_reg) & set_mask[ADDR_W-1:0];
        lk_set      = set_full[SET_W-1:0];
        lk_tag      = (shift_amt >= SHIFT_W'(32)) ? '0 : address >> shift_amt;
        sets_in_use = FILL_W'(1) << ib_eff;
    end

    always_comb
    begin
        miss = 1'b1;
        priority if (!rd_reg.valid)
        begin
            outcome_next = OUT_COMPULSORY;
        end
        else if (rd_reg.tag == tag_reg)
        begin
            outcome_next = OUT_HIT;
            miss         = 1'b0;
        end
        else if (filled_lines_reg >= sets_in_use)
        begin
            outcome_next = OUT_CAPACITY;
        end
        else
        begin
            outcome_next = OUT_CONFLICT;
        end

        mem_we    = cmd.clear_wr || (cmd.update && miss);
        mem_waddr = cmd.clear_wr ? clr_cnt_reg : set_reg;
        mem_wdata = cmd.clear_wr ? line_t'('0) : line_t'({1'b1, tag_reg});

        clr_cnt_next      = cmd.clear_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        filled_lines_next = (cmd.update && outcome_next == OUT_COMPULSORY)
                          ? filled_lines_reg + 1'b1 : filled_lines_reg;
        out_valid_next    = cmd.update ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        status.clear_last = (clr_cnt_reg == SET_W'(MAX_SETS - 1));
        status.out_stall  = out_valid_reg && !out_ready;

        set_ext = 32'(set_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.lookup)
        begin
            rd_reg <= mem[lk_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg      <= '0;
            filled_lines_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clr_cnt_reg      <= clr_cnt_next;
            filled_lines_reg <= filled_lines_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            set_reg <= lk_set;
            tag_reg <= lk_tag;
        end
        if (cmd.update)
        begin
            outcome_reg   <= outcome_next;
            set_index_reg <= set_ext[SET_OUT_W-1:0];
            tag_value_reg <= tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign set_index = set_index_reg;
    assign tag_value = tag_value_reg;

    `DMC_ASSERT(a_no_overwrite, !(cmd.update && out_valid_reg && !out_ready), "result overwritten before taken")
    `DMC_ASSERT(a_fill_bound, filled_lines_reg <= FILL_W'(MAX_SETS), "filled line count beyond set count")
    `DMC_ASSERT_NEXT(a_fill_count, cmd.update && outcome_next == OUT_COMPULSORY, filled_lines_reg == FILL_W'($past(filled_lines_reg) + 1'b1), "compulsory miss not counted")

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_cache_miss_classifier.sv =====
`default_nettype none

// Direct-mapped cache tag store with hit / compulsory / conflict / capacity classification.
// After reset a clearing pass sweeps all MAX_SETS lines of the tag RAM (1024 by default), one
// line a cycle, with in_ready low; configuration writes are taken throughout. For each item the
// tag RAM is read at the accepting edge; the update state, which writes back a missed line,
// waits until the output register is free, and no address is accepted before it is left. The
// result sits in an output register, and the next address is accepted while it waits to be taken.

module direct_mapped_cache_miss_classifier
    import dmc_pkg::*;
#(
    parameter int MAX_SETS = DMC_MAX_SETS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  write_en,
    input  wire logic [CFG_IDX_W-1:0]  reg_index,
    input  wire logic [CFG_DATA_W-1:0] write_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [ADDR_W-1:0]     address,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 outcome,
    output logic [SET_OUT_W-1:0]       set_index,
    output logic [TAG_W-1:0]           tag_value
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dmc_datapath #(
        .MAX_SETS (MAX_SETS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .address    (address),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .outcome    (outcome),
        .set_index  (set_index),
        .tag_value  (tag_value)
    );

endmodule

`default_nettype wire

// ===== verif/direct_mapped_cache_miss_classifier_checker.sv =====
`timescale 1ns / 1ps

module direct_mapped_cache_miss_classifier_checker
    import dmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  reg_index,
    input  logic [CFG_DATA_W-1:0] write_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            outcome,
    input  logic [SET_OUT_W-1:0]  set_index,
    input  logic [TAG_W-1:0]      tag_value,
    output int                    fail_count,
    output int                    pending
);

    localparam int MAX_INDEX_BITS = $clog2(DMC_MAX_SETS);
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        outcome_t              kind;
        logic [SET_OUT_W-1:0]  line_no;
        logic [TAG_W-1:0]      tag;
    } lookup_t;

    logic [OFFSET_W-1:0] offset_sel;
    logic [INDEX_W-1:0]  index_sel;
    logic                valid_bits [DMC_MAX_SETS];
    logic [TAG_W-1:0]    stored_tags [DMC_MAX_SETS];
    int unsigned         lines_filled;
    lookup_t             lookups_due [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic lookup_t look_up_address(input logic [ADDR_W-1:0] a);
        int unsigned ib;
        int unsigned sets_used;
        int unsigned tag_shift;
        lookup_t     r;
        ib        = (index_sel > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_sel;
        sets_used = 1 << ib;
        tag_shift = offset_sel + ib;
        r.line_no = SET_OUT_W'((a >> offset_sel) & (sets_used - 1));
        r.tag     = (tag_shift >= TAG_W) ? '0 : a >> tag_shift;
        if (!valid_bits[r.line_no])
        begin
            r.kind                  = OUT_COMPULSORY;
            valid_bits[r.line_no]   = 1'b1;
            stored_tags[r.line_no]  = r.tag;
            lines_filled++;
        end
        else if (stored_tags[r.line_no] == r.tag)
        begin
            r.kind = OUT_HIT;
        end
        else
        begin
            r.kind = (lines_filled >= sets_used) ? OUT_CAPACITY : OUT_CONFLICT;
            stored_tags[r.line_no] = r.tag;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t due;
        if (!rst_n)
        begin
            offset_sel   = OFFSET_RESET;
            index_sel    = INDEX_RESET;
            lines_filled = 0;
            foreach (valid_bits[i])
                valid_bits[i] = 1'b0;
            lookups_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (lookups_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%t: unexpected result outcome %0d set %0d tag %h",
                                 $realtime, outcome, set_index, tag_value);
                end
                else
                begin
                    due = lookups_due.pop_front();
                    if (outcome !== due.kind || set_index !== due.line_no
                        || tag_value !== due.tag)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%t: mismatch, expected %0d/%0d/%h, got %0d/%0d/%h",
                                     $realtime, due.kind, due.line_no, due.tag,
                                     outcome, set_index, tag_value);
                    end
                end
            end
            if (in_valid && in_ready)
                lookups_due.push_back(look_up_address(address));
            if (write_en)
            begin
                case (reg_index)
                    REG_OFFSET_BITS: offset_sel = write_data[OFFSET_W-1:0];
                    REG_INDEX_BITS:  index_sel  = write_data[INDEX_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = lookups_due.size();
    end

endmodule

// ===== verif/direct_mapped_cache_miss_classifier_tb.sv =====
`timescale 1ns / 1ps

module direct_mapped_cache_miss_classifier_tb;
    import dmc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int MAX_INDEX_BITS = $clog2(DMC_MAX_SETS);
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 165;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  write_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  reg_index  = '0;
    logic [CFG_DATA_W-1:0] write_data = '0;
    logic                  in_valid   = 1'b0;
    logic [ADDR_W-1:0]     address    = '0;
    logic                  out_ready  = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [1:0]            outcome;
    logic [SET_OUT_W-1:0]  set_index;
    logic [TAG_W-1:0]      tag_value;
    int                    fail_count;
    int                    pending;

    int unsigned send_idle   = 0;
    int unsigned recv_stall  = 0;
    int unsigned hold_cycles = 0;
    int unsigned geo_off     = 2;
    int unsigned geo_ib      = 8;
    logic [TAG_W-1:0] tag_pool [4];

    int unsigned phase_off   [PHASES] = '{2, 4, 0, 6, 16, 0, 31, 10};
    int unsigned phase_idx   [PHASES] = '{8, 3, 10, 12, 10, 0, 15, 6};
    int unsigned phase_send  [PHASES] = '{0, 70, 0, 32, 0, 70, 0, 32};
    int unsigned phase_recv  [PHASES] = '{0, 0, 70, 32, 0, 0, 70, 32};
    int unsigned phase_hold  [PHASES] = '{300, 0, 0, 0, 0, 0, 0, 0};

    direct_mapped_cache_miss_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .address    (address),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .outcome    (outcome),
        .set_index  (set_index),
        .tag_value  (tag_value)
    );

    direct_mapped_cache_miss_classifier_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .address    (address),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .outcome    (outcome),
        .set_index  (set_index),
        .tag_value  (tag_value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] r,
                             input logic [CFG_DATA_W-1:0] d);
        write_en   <= 1'b1;
        reg_index  <= r;
        write_data <= d;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] off,
                             input logic [CFG_DATA_W-1:0] idx,
                             input bit spare);
        wait_drained();
        if (spare)
        begin
            write_reg(REG_SPARE_A, 5'b11111);
            write_reg(REG_SPARE_B, 5'b10101);
        end
        write_reg(REG_OFFSET_BITS, off);
        write_reg(REG_INDEX_BITS, idx);
        write_en <= 1'b0;
        geo_off = off;
        geo_ib  = (idx[INDEX_W-1:0] > MAX_INDEX_BITS) ? MAX_INDEX_BITS : idx[INDEX_W-1:0];
    endtask

    task automatic send_addr(input logic [ADDR_W-1:0] a);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        address  <= a;
        do @(posedge clk); while (!in_ready);
    endtask

    // mostly few tags over a narrow band of lines, so hits and conflicts recur
    function automatic logic [ADDR_W-1:0] shaped_address();
        logic [63:0] word;
        logic [63:0] line_no;
        int unsigned pick;
        word = 64'($urandom);
        pick = $urandom_range(99);
        if (pick >= 15)
        begin
            line_no = (pick < 70) ? 64'($urandom_range(7)) : 64'($urandom);
            line_no &= (64'd1 << geo_ib) - 1;
            word = (word & ((64'd1 << geo_off) - 1)) | (line_no << geo_off)
                 | (64'(tag_pool[$urandom_range(3)]) << (geo_off + geo_ib));
        end
        return word[ADDR_W-1:0];
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // default geometry, during the clearing pass
        send_addr(32'h0000_0000);
        send_addr(32'h0000_0000);
        send_addr(32'h0000_0003);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'h0000_0400);
        send_addr(32'h0000_0000);
        send_addr(32'h0000_07FC);

        // single line; writes to unused indexes must be ignored
        configure(5'd0, 5'd0, 1'b1);
        send_addr(32'h1234_5678);
        send_addr(32'h1234_5678);
        send_addr(32'hFFFF_FFFF);

        // index clamped, tag shifted out completely
        configure(5'd31, 5'd15, 1'b0);
        send_addr(32'h8000_0000);
        send_addr(32'h7FFF_FFFF);

        configure(5'd22, 5'd10, 1'b0);
        send_addr(32'hFFC0_0000);
        send_addr(32'hFFFF_FFFF);

        // offset of 20, top data bit set on the index register
        configure(5'd20, 5'b11011, 1'b0);
        send_addr(32'hC000_0000);

        configure(5'd16, 5'd0, 1'b0);
        send_addr(32'hABCD_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            configure(CFG_DATA_W'(phase_off[p]), CFG_DATA_W'(phase_idx[p]), 1'b0);
            send_idle   = phase_send[p];
            recv_stall  = phase_recv[p];
            hold_cycles = phase_hold[p];
            foreach (tag_pool[k])
                tag_pool[k] = $urandom;
            repeat (PHASE_ITEMS) send_addr(shaped_address());
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("direct_mapped_cache_miss_classifier_tb passed");
        else
            $display("direct_mapped_cache_miss_classifier_tb failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("direct_mapped_cache_miss_classifier_tb failed");
        $finish;
    end

endmodule
